@@ rtl/core/ele_pkg.sv @@
// Shared types and constants for the epoch leader elector.
// Item payload structs, register indexes, reset values and the table
// request/status structs. No dependencies.
package ele_pkg;

	localparam int RANK_W     = 7;
	localparam int EPOCH_W    = 31;
	localparam int FIRST_W    = 16;
	localparam int STEP_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 31;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PEER_COUNT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_RANK     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_EPOCH    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_PERIOD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_STEP  = 3'd4;

	// item commands
	localparam logic CMD_HEARTBEAT = 1'b0;
	localparam logic CMD_TICK      = 1'b1;

	// reset values
	localparam logic [RANK_W-1:0]  RST_PEER_COUNT   = 7'd64;
	localparam logic [RANK_W-1:0]  RST_OWN_RANK     = 7'd1;
	localparam logic [EPOCH_W-1:0] RST_OWN_EPOCH    = 31'd1;
	localparam logic [FIRST_W-1:0] RST_FIRST_PERIOD = 16'd4;
	localparam logic [STEP_W-1:0]  RST_PERIOD_STEP  = 8'd2;

	typedef struct packed {
		logic               cmd;
		logic [RANK_W-1:0]  sender;
		logic [EPOCH_W-1:0] epoch;
	} in_item_t;

	typedef struct packed {
		logic [RANK_W-1:0] leader;
		logic              leader_changed;
		logic              send_heartbeats;
	} out_item_t;

	// request to the peer table: one-cycle pulses plus operands
	typedef struct packed {
		logic               hb;
		logic               scan;
		logic [RANK_W-1:0]  rank;
		logic [EPOCH_W-1:0] epoch;
		logic [RANK_W-1:0]  limit;
		logic [RANK_W-1:0]  own_rank;
		logic [EPOCH_W-1:0] own_epoch;
	} tbl_req_t;

	typedef struct packed {
		logic              done;
		logic [RANK_W-1:0] best_rank;
	} tbl_sts_t;

endpackage

@@ rtl/core/ele_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// Parameterised width and depth; no dependencies.
module ele_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 64
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/core/ele_table.sv @@
// Peer table: per-peer seen flags plus epoch RAM, heartbeat read-modify-write
// and the end-of-round sweep for the best candidate.
// Depends on ele_pkg and ele_ram.
module ele_table #(
	parameter int MAX_PEERS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ele_pkg::tbl_req_t req,
	output ele_pkg::tbl_sts_t sts
);
	import ele_pkg::*;

	localparam int IW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;

	typedef enum logic [2:0] {ST_IDLE, ST_HB_WR, ST_SCAN, ST_DRAIN, ST_FIN} state_t;

	state_t               state_q;
	logic [MAX_PEERS-1:0] seen_q;
	logic [IW-1:0]        hb_idx_q;
	logic [EPOCH_W-1:0]   hb_epoch_q;
	logic [RANK_W-1:0]    cnt_q;
	logic [RANK_W-1:0]    limit_q;
	logic [RANK_W-1:0]    best_rank_q;
	logic [EPOCH_W-1:0]   best_epoch_q;
	logic                 v_s1;
	logic                 seen_s1;
	logic [RANK_W-1:0]    rank_s1;

	logic [IW-1:0]        hb_idx;
	logic [IW-1:0]        rd_addr;
	logic [EPOCH_W-1:0]   rd_data;
	logic                 we;
	logic                 better;
	logic [RANK_W-1:0]    cnt_nxt;

	assign hb_idx  = IW'(req.rank - 7'd1);
	assign cnt_nxt = cnt_q + 7'd1;
	assign rd_addr = (state_q == ST_SCAN) ? IW'(cnt_q) : hb_idx;
	// first heartbeat of the round always lands; later ones only if higher
	assign we      = (state_q == ST_HB_WR) && (!seen_q[hb_idx_q] || rd_data < hb_epoch_q);
	assign better  = seen_s1 && ((rd_data < best_epoch_q) ||
		((rd_data == best_epoch_q) && (rank_s1 > best_rank_q)));

	ele_ram #(
		.WIDTH(EPOCH_W),
		.DEPTH(MAX_PEERS)
	) u_epoch_ram (
		.clk  (clk),
		.we   (we),
		.waddr(hb_idx_q),
		.wdata(hb_epoch_q),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seen_q  <= '0;
			v_s1    <= 1'b0;
			cnt_q   <= '0;
		end else begin
			v_s1 <= (state_q == ST_SCAN);
			case (state_q)
				ST_IDLE: begin
					if (req.hb) begin
						state_q <= ST_HB_WR;
					end else if (req.scan) begin
						cnt_q   <= '0;
						state_q <= (req.limit == '0) ? ST_DRAIN : ST_SCAN;
					end
				end
				ST_HB_WR: begin
					seen_q[hb_idx_q] <= 1'b1;
					state_q          <= ST_IDLE;
				end
				ST_SCAN: begin
					cnt_q <= cnt_nxt;
					if (cnt_nxt == limit_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// last compare lands on this edge; new round starts empty
					seen_q  <= '0;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.hb) begin
			hb_idx_q   <= hb_idx;
			hb_epoch_q <= req.epoch;
		end
		if (state_q == ST_IDLE && !req.hb && req.scan) begin
			best_rank_q  <= req.own_rank;
			best_epoch_q <= req.own_epoch;
			limit_q      <= req.limit;
		end else if (v_s1 && better) begin
			best_rank_q  <= rank_s1;
			best_epoch_q <= rd_data;
		end
		seen_s1 <= seen_q[IW'(cnt_q)];
		rank_s1 <= cnt_nxt;
	end

	assign sts.done      = (state_q == ST_HB_WR) || (state_q == ST_FIN);
	assign sts.best_rank = best_rank_q;

endmodule

@@ rtl/core/epoch_leader_elector.sv @@
// Top level of the epoch leader elector: handshakes, configuration
// registers, round timer and sequencing. Depends on ele_pkg and ele_table.
//
// One transaction in, one transaction out. The block handles one item at a
// time; the next item is taken as soon as the result sits in the output
// register, even if the consumer has not yet taken it. A heartbeat goes
// from acceptance to a loaded result through epoch RAM read, compare and
// write-back, and result load. A tick that does not end the round, or a
// heartbeat from an invalid sender, goes straight to the result load.
// A tick that ends the round sweeps the peer table, one rank per cycle
// through the epoch RAM read port. Per-peer epochs live in a RAM of
// MAX_PEERS entries; the seen-this-round flags are flops, cleared at reset
// and at every round end, so no clearing pass is needed after reset. The
// configuration port is always ready; write registers only while no
// transaction is outstanding. A write to peer_count also resets the
// trusted leader, and a write to first_period restarts the round. Round
// lengths saturate at 2^PERIOD_BITS-1.
module epoch_leader_elector #(
	parameter int MAX_PEERS   = 64,
	parameter int PERIOD_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  ele_pkg::in_item_t                   in_item,
	output logic                                out_valid,
	input  logic                                out_ready,
	output ele_pkg::out_item_t                  out_item,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ele_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ele_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import ele_pkg::*;

	localparam int              SW      = ((PERIOD_BITS > STEP_W) ? PERIOD_BITS : STEP_W) + 1;
	localparam logic [32:0]     PMAX33  = (33'd1 << PERIOD_BITS) - 33'd1;
	localparam logic [SW-1:0]   PMAX_S  = SW'(PMAX33);
	localparam logic [8:0]      MAXP9   = 9'(MAX_PEERS);

	typedef enum logic [1:0] {ST_IDLE, ST_WAIT_HB, ST_WAIT_SCAN, ST_RESULT} state_t;

	// control state
	state_t                 state_q;
	logic                   out_valid_q;
	logic [RANK_W-1:0]      peer_count_q;
	logic [RANK_W-1:0]      own_rank_q;
	logic [EPOCH_W-1:0]     own_epoch_q;
	logic [STEP_W-1:0]      period_step_q;
	logic [RANK_W-1:0]      leader_q;
	logic [PERIOD_BITS-1:0] round_q;
	logic [PERIOD_BITS-1:0] ticks_q;
	logic                   changed_q;
	logic                   send_q;
	out_item_t              out_q;

	tbl_req_t               req;
	tbl_sts_t               sts;

	logic                   in_acc;
	logic                   cfg_acc;
	logic [RANK_W-1:0]      limit;
	logic                   sender_ok;
	logic                   round_end;
	logic [32:0]            fp_wide;
	logic [PERIOD_BITS-1:0] fp_clamped;
	logic [SW-1:0]          round_sum;
	logic [PERIOD_BITS-1:0] round_next;
	logic                   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign out_free  = !out_valid_q || out_ready;

	// ranks 1..min(peer_count, MAX_PEERS) take part
	assign limit     = ({2'b00, peer_count_q} > MAXP9) ? RANK_W'(MAXP9) : peer_count_q;
	assign sender_ok = (in_item.sender != '0) && (in_item.sender <= limit);
	assign round_end = (ticks_q <= PERIOD_BITS'(1));

	// first_period write: clamp to the counter range
	assign fp_wide    = 33'(cfg_data[FIRST_W-1:0]);
	assign fp_clamped = (fp_wide > PMAX33) ? PERIOD_BITS'(PMAX33) : PERIOD_BITS'(fp_wide);

	// lengthened round on a leader change, saturating
	assign round_sum  = SW'(round_q) + SW'(period_step_q);
	assign round_next = (round_sum > PMAX_S) ? PERIOD_BITS'(PMAX_S) : PERIOD_BITS'(round_sum);

	// table requests go out in the accept cycle so the RAM read starts at once
	always_comb begin
		req           = '0;
		req.hb        = in_acc && (in_item.cmd == CMD_HEARTBEAT) && sender_ok;
		req.scan      = in_acc && (in_item.cmd == CMD_TICK) && round_end;
		req.rank      = in_item.sender;
		req.epoch     = in_item.epoch;
		req.limit     = limit;
		req.own_rank  = own_rank_q;
		req.own_epoch = own_epoch_q;
	end

	ele_table #(
		.MAX_PEERS(MAX_PEERS)
	) u_table (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.sts   (sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			out_valid_q    <= 1'b0;
			peer_count_q   <= RST_PEER_COUNT;
			own_rank_q     <= RST_OWN_RANK;
			own_epoch_q    <= RST_OWN_EPOCH;
			period_step_q  <= RST_PERIOD_STEP;
			leader_q       <= RST_PEER_COUNT;
			round_q        <= PERIOD_BITS'(RST_FIRST_PERIOD);
			ticks_q        <= PERIOD_BITS'(RST_FIRST_PERIOD);
			changed_q      <= 1'b0;
			send_q         <= 1'b0;
		end else begin
			// a taken result is replaced below when the next one is ready
			if (out_valid_q && out_ready && state_q != ST_RESULT) begin
				out_valid_q <= 1'b0;
			end

			// register writes; the user writes only while idle, the block does not enforce it
			if (cfg_acc) begin
				case (cfg_index)
					REG_PEER_COUNT: begin
						peer_count_q <= cfg_data[RANK_W-1:0];
						leader_q     <= cfg_data[RANK_W-1:0];
					end
					REG_OWN_RANK: begin
						own_rank_q <= cfg_data[RANK_W-1:0];
					end
					REG_OWN_EPOCH: begin
						own_epoch_q <= cfg_data[EPOCH_W-1:0];
					end
					REG_FIRST_PERIOD: begin
						round_q        <= fp_clamped;
						ticks_q        <= fp_clamped;
					end
					REG_PERIOD_STEP: begin
						period_step_q <= cfg_data[STEP_W-1:0];
					end
					default: begin
					end
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						changed_q <= 1'b0;
						send_q    <= 1'b0;
						if (req.hb) begin
							state_q <= ST_WAIT_HB;
						end else if (req.scan) begin
							state_q <= ST_WAIT_SCAN;
						end else begin
							// ignored heartbeat or plain countdown tick
							if (in_item.cmd == CMD_TICK) begin
								ticks_q <= ticks_q - PERIOD_BITS'(1);
							end
							state_q <= ST_RESULT;
						end
					end
				end
				ST_WAIT_HB: begin
					if (sts.done) begin
						state_q <= ST_RESULT;
					end
				end
				ST_WAIT_SCAN: begin
					if (sts.done) begin
						send_q  <= 1'b1;
						state_q <= ST_RESULT;
						if (sts.best_rank != leader_q) begin
							leader_q  <= sts.best_rank;
							round_q   <= round_next;
							ticks_q   <= round_next;
							changed_q <= 1'b1;
						end else begin
							ticks_q <= round_q;
						end
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_RESULT && out_free) begin
			out_q.leader          <= leader_q;
			out_q.leader_changed  <= changed_q;
			out_q.send_heartbeats <= send_q;
		end
	end

endmodule
